@@ src/cpr_pkg.sv @@
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int CFG_W   = 5;
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int FAULT_W = 32;

    localparam logic [CFG_W-1:0] NUM_FRAMES_RST = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch a new reference word
        logic look;      // lookup sweep over the frames
        logic scan;      // clock hand sweep over the reference bits
        logic fin_hit;   // finish with a hit
        logic fin_miss;  // finish with a fault, replace the frame under the hand
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;     // compared frame holds the page
        logic cmp_last;  // compared frame is the last active one
        logic ref_set;   // reference bit under the hand is set
    } t_dp_sts;

endpackage

@@ src/cpr_ram.sv @@
`timescale 1ns / 1ps

module cpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cpr_ctrl.sv @@
`timescale 1ns / 1ps

module cpr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cpr_pkg::t_dp_sts i_sts,
    output cpr_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import cpr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_EVICT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_busy;
    logic    n_busy;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_LOOK;
                    n_busy   = 1'b1;
                end
            end
            S_LOOK: begin
                cmd.look = 1'b1;
                if (i_sts.match) begin
                    cmd.fin_hit = 1'b1;
                    n_state     = S_IDLE;
                    n_busy      = 1'b0;
                end else if (i_sts.cmp_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (!i_sts.ref_set) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                cmd.fin_miss = 1'b1;
                n_state      = S_IDLE;
                n_busy       = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule

@@ src/cpr_dp.sv @@
`timescale 1ns / 1ps

module cpr_dp #(
    parameter int FRAMES_MAX = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpr_pkg::t_dp_cmd              i_cmd,
    output cpr_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [cpr_pkg::PAGE_W-1:0]    i_page_number,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [cpr_pkg::SLOT_W-1:0]    o_slot,
    output logic                          o_evicted_valid,
    output logic [cpr_pkg::PAGE_W-1:0]    o_evicted_page,
    output logic [cpr_pkg::FAULT_W-1:0]   o_fault_total
);
    import cpr_pkg::*;

    localparam int IW = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
    localparam int CW = $clog2(FRAMES_MAX + 1);

    logic [CFG_W-1:0]     r_num_frames;
    logic [PAGE_BITS-1:0] r_page;
    logic [IW-1:0]        r_hand;
    logic [CW-1:0]        r_idx;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_cmp_vld;
    logic [FRAMES_MAX-1:0] r_valid;
    logic [FRAMES_MAX-1:0] r_ref;
    logic [FAULT_W-1:0]   r_fault;

    logic                 r_out_vld;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_ev_vld;
    logic [PAGE_W-1:0]    r_ev_page;
    logic [FAULT_W-1:0]   r_fault_out;

    logic [CW-1:0]        n_act;
    logic [CW-1:0]        n_last;
    logic [IW-1:0]        hand_adv;
    logic                 issue;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [PAGE_BITS-1:0] ram_rdata;
    logic [FAULT_W-1:0]   fault_inc;
    logic                 match;

    // Active frame count, clamped to the range the frame store holds.
    always_comb begin
        priority if (r_num_frames == '0) begin
            n_act = CW'(1);
        end else if (32'(r_num_frames) > 32'(FRAMES_MAX)) begin
            n_act = CW'(FRAMES_MAX);
        end else begin
            n_act = CW'(r_num_frames);
        end
    end

    assign n_last    = n_act - CW'(1);
    assign hand_adv  = (32'(r_hand) == 32'(n_last)) ? '0 : r_hand + IW'(1);
    assign issue     = i_cmd.look && (r_idx < n_act);
    assign ram_re    = issue || i_cmd.scan;
    assign ram_raddr = i_cmd.scan ? r_hand : r_idx[IW-1:0];
    assign fault_inc = (r_fault == '1) ? r_fault : r_fault + FAULT_W'(1);
    assign match     = r_cmp_vld && r_valid[r_cmp_idx] && (ram_rdata == r_page);

    assign o_sts.match    = match;
    assign o_sts.cmp_last = r_cmp_vld && (32'(r_cmp_idx) == 32'(n_last));
    assign o_sts.ref_set  = r_ref[r_hand];

    cpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES_MAX),
        .AW    (IW)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fin_miss),
        .i_waddr (r_hand),
        .i_wdata (r_page),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_frames <= NUM_FRAMES_RST;
            r_hand       <= '0;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_valid      <= '0;
            r_ref        <= '0;
            r_fault      <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.fin_hit || i_cmd.fin_miss;
            if (i_cfg_we) begin
                r_num_frames <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                // A hand left beyond a shrunken frame count restarts at frame 0.
                if (32'(r_hand) >= 32'(n_act)) begin
                    r_hand <= '0;
                end
            end
            if (i_cmd.look) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (i_cmd.scan && r_ref[r_hand]) begin
                r_ref[r_hand] <= 1'b0;
                r_hand        <= hand_adv;
            end
            if (i_cmd.fin_hit) begin
                r_ref[r_cmp_idx] <= 1'b1;
            end
            if (i_cmd.fin_miss) begin
                r_valid[r_hand] <= 1'b1;
                r_ref[r_hand]   <= 1'b0;
                r_hand          <= hand_adv;
                r_fault         <= fault_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= PAGE_BITS'(i_page_number);
        end
        if (issue) begin
            r_cmp_idx <= r_idx[IW-1:0];
        end
        if (i_cmd.fin_hit) begin
            r_hit       <= 1'b1;
            r_slot      <= SLOT_W'(r_cmp_idx);
            r_ev_vld    <= 1'b0;
            r_ev_page   <= '0;
            r_fault_out <= r_fault;
        end else if (i_cmd.fin_miss) begin
            r_hit       <= 1'b0;
            r_slot      <= SLOT_W'(r_hand);
            r_ev_vld    <= r_valid[r_hand];
            r_ev_page   <= r_valid[r_hand] ? PAGE_W'(ram_rdata) : '0;
            r_fault_out <= fault_inc;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_hit           = r_hit;
    assign o_slot          = r_slot;
    assign o_evicted_valid = r_ev_vld;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault_out;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan || i_cmd.fin_miss) |-> (32'(r_hand) < 32'(n_act)))
        else $error("clock hand outside the active frames");

    a_fill_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_miss |=> r_valid[$past(r_hand)])
        else $error("replaced frame not marked valid");

    a_hit_needs_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_hit |-> r_cmp_vld)
        else $error("hit reported without a compared frame");

    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_hit) |-> (r_fault_out != '0))
        else $error("fault word with zero fault total");

endmodule

@@ src/clock_page_replacement.sv @@
`timescale 1ns / 1ps

// Clock (second-chance) page replacement engine.
// Input channel: drive i_page_number and raise start; the word is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// result has been formed, and then drops so the next word can be taken.
// Result channel: o_valid is high for exactly one cycle with o_hit, o_slot,
// o_evicted_valid, o_evicted_page and o_fault_total. The receiver cannot stall
// this channel, so it must take each result word in the cycle it appears.
// Configuration channel: i_cfg_valid with i_cfg_data writes the frame count;
// o_cfg_ready is always high. Write it only while the engine is idle.
// Sequence: the lookup reads one frame per cycle through the registered RAM port,
// and a hit ends it at the matching frame. A miss runs the lookup over all N
// active frames, then the hand clears at most N set reference bits, one per
// cycle, stops on the first clear bit, and the evict step replaces that frame.
// busy drops as the result appears, so the next word can be taken at the edge
// that ends the result cycle.
// Reset (synchronous, active low) empties every frame, clears the reference
// bits, the hand and the fault total, and sets the frame count to 16.

module clock_page_replacement #(
    parameter int FRAMES_MAX = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cpr_pkg::PAGE_W-1:0]    i_page_number,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cpr_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [cpr_pkg::SLOT_W-1:0]    o_slot,
    output logic                          o_evicted_valid,
    output logic [cpr_pkg::PAGE_W-1:0]    o_evicted_page,
    output logic [cpr_pkg::FAULT_W-1:0]   o_fault_total
);
    import cpr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    busy_int;

    // The frame count register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign busy        = busy_int;

    // The controller sequences lookup, hand sweep and replacement.
    cpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy_int)
    );

    // The datapath holds the frame store, reference bits, hand and counters.
    cpr_dp #(
        .FRAMES_MAX (FRAMES_MAX),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import cpr_pkg::*;

    localparam int FRAMES    = 16;
    localparam int POOL_SIZE = 32;
    localparam int PHASES    = 10;
    localparam int PHASE_LEN = 170;
    localparam int DRAIN_WAIT = 3 * FRAMES + 8;

    // One result word, in port order.
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_total;
    } access_result_t;

    // One row of the directed stimulus table. When typed is set, the row carries
    // the result word that is obvious by inspection and that word is checked.
    typedef struct {
        logic [PAGE_W-1:0] page;
        bit                typed;
        access_result_t    res;
    } access_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [PAGE_W-1:0]  i_page_number = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               o_valid;
    logic               o_hit;
    logic [SLOT_W-1:0]  o_slot;
    logic               o_evicted_valid;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [FAULT_W-1:0] o_fault_total;

    clock_page_replacement uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

    // Shadow copy of the replacement state, kept in step with the engine.
    logic [CFG_W-1:0]   frame_cfg;
    logic [PAGE_W-1:0]  frame_page [FRAMES];
    bit                 frame_valid [FRAMES];
    bit                 frame_ref [FRAMES];
    int unsigned        hand_pos;
    logic [FAULT_W-1:0] faults_seen;

    // Result words that the engine still owes, oldest first.
    access_result_t pending_results [$];
    int unsigned    mismatches = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the engine hangs or drops a handshake.
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // A count of zero behaves as one frame and anything above the store depth
    // behaves as the full store.
    function automatic int unsigned frames_in_use();
        if (frame_cfg == 0) return 1;
        if (frame_cfg > FRAMES) return FRAMES;
        return int'(frame_cfg);
    endfunction

    // Second-chance lookup and replacement for one page reference. Updates the
    // shadow state and returns the result word the engine must produce.
    function automatic access_result_t predict_access(input logic [PAGE_W-1:0] page);
        access_result_t r;
        int unsigned    n;
        int unsigned    k;
        int unsigned    sweeps;
        r = '0;
        n = frames_in_use();
        // The hand may sit outside the active frames after the count shrank.
        if (hand_pos >= n) hand_pos = 0;
        // Lowest active frame wins when a page is held twice.
        for (k = 0; k < n; k++) begin
            if (frame_valid[k] && frame_page[k] == page) begin
                r.hit = 1'b1;
                r.slot = k[SLOT_W-1:0];
                frame_ref[k] = 1'b1;
                break;
            end
        end
        if (!r.hit) begin
            // Give every referenced frame its second chance; after one full
            // pass all bits are clear, so the walk always terminates.
            for (sweeps = 0; sweeps < 2 * n + 1; sweeps++) begin
                if (!frame_ref[hand_pos]) break;
                frame_ref[hand_pos] = 1'b0;
                hand_pos = (hand_pos + 1 >= n) ? 0 : hand_pos + 1;
            end
            r.slot = hand_pos[SLOT_W-1:0];
            if (frame_valid[hand_pos]) begin
                r.evicted_valid = 1'b1;
                r.evicted_page = frame_page[hand_pos];
            end
            frame_page[hand_pos] = page;
            frame_valid[hand_pos] = 1'b1;
            frame_ref[hand_pos] = 1'b0;
            hand_pos = (hand_pos + 1 >= n) ? 0 : hand_pos + 1;
            if (faults_seen != '1) faults_seen = faults_seen + 1'b1;
        end
        r.fault_total = faults_seen;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // Present one page reference, with random idle cycles in front of it, and
    // hold it until the engine takes it. start is left high on return so that a
    // back-to-back word needs no second assignment in the same time step.
    task automatic send_access(input logic [PAGE_W-1:0] page, input int unsigned idle_pct,
                               input bit typed, input access_result_t typed_res);
        access_result_t predicted;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = predict_access(page);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Stop sending and wait until every owed result word has come back and the
    // engine reports idle. Must be called in the step of the last acceptance,
    // so start drops before the engine could take the same word again.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        frame_cfg = value;
    endtask

    task automatic add_row(input logic [PAGE_W-1:0] page, input bit typed,
                           input access_result_t res, inout access_row_t rows [$]);
        access_row_t row;
        row.page = page;
        row.typed = typed;
        row.res = res;
        rows.push_back(row);
    endtask

    // Result checker. The result word is on the ports for the one cycle that
    // ends at this edge; it is compared with the oldest owed word.
    always @(posedge i_clk) begin
        access_result_t want;
        access_result_t got;
        if (i_rst_n && o_valid === 1'b1) begin
            got = {o_hit, o_slot, o_evicted_valid, o_evicted_page, o_fault_total};
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf({"unexpected result word: hit %b slot %0d ev %b",
                    " page %h total %0d"},
                    got.hit, got.slot, got.evicted_valid, got.evicted_page, got.fault_total));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    note_mismatch($sformatf({"result mismatch: expected hit %b slot %0d ev %b page %h",
                        " total %0d, got hit %b slot %0d ev %b page %h total %0d"},
                        want.hit, want.slot, want.evicted_valid, want.evicted_page,
                        want.fault_total, got.hit, got.slot, got.evicted_valid,
                        got.evicted_page, got.fault_total));
                end
            end
        end
    end

    initial begin
        access_row_t       rows [$];
        access_result_t    no_res;
        logic [PAGE_W-1:0] pool [POOL_SIZE];
        logic [PAGE_W-1:0] page;
        logic [CFG_W-1:0]  phase_frames [PHASES];
        logic [CFG_W-1:0]  setting;
        int unsigned       span;
        int unsigned       idle_pct;
        int unsigned       n;
        int                k;
        int                p;

        no_res = '0;
        frame_cfg = NUM_FRAMES_RST;
        hand_pos = 0;
        faults_seen = '0;
        for (k = 0; k < FRAMES; k++) begin
            frame_page[k] = '0;
            frame_valid[k] = 1'b0;
            frame_ref[k] = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run at the reset frame count of 16. The first four
        // words follow directly from an empty store: two faults fill frames 0
        // and 1, and the repeats hit there and set their reference bits.
        add_row(16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}, rows);
        add_row(16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}, rows);
        add_row(16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}, rows);
        add_row(16'hFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd2}, rows);
        add_row(16'h5555, 1'b0, no_res, rows);
        add_row(16'hAAAA, 1'b0, no_res, rows);
        // Fill the rest of the store so the hand wraps to frame 0.
        for (k = 0; k < FRAMES - 4; k++) add_row(PAGE_W'(16'h0100 + k), 1'b0, no_res, rows);
        // Full store: the hand skips frames 0 and 1 (second chance) and evicts
        // frame 2; the next fault evicts the unreferenced frame 3.
        add_row(16'h1234, 1'b0, no_res, rows);
        add_row(16'h5555, 1'b0, no_res, rows);
        add_row(16'h1234, 1'b0, no_res, rows);
        add_row(16'h0000, 1'b0, no_res, rows);

        foreach (rows[i]) send_access(rows[i].page, 0, rows[i].typed, rows[i].res);
        wait_idle();

        // Random part. Each phase sets a new frame count, including zero, the
        // extremes and values past the store depth. Shrinking after use leaves
        // the hand and stale frames beyond the active count, and growing again
        // brings stale copies of a page back into view.
        phase_frames = '{5'd4, 5'd1, 5'd0, 5'd16, 5'd31, 5'd2, 5'd17, 5'd8, 5'd0, 5'd16};
        for (k = 0; k < POOL_SIZE; k++) pool[k] = PAGE_W'($urandom_range(0, 16'hFFFF));
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;

        for (p = 0; p < PHASES; p++) begin
            // Phase eight takes a random count from the whole register range.
            setting = (p == 8) ? CFG_W'($urandom_range(0, 31)) : phase_frames[p];
            write_frames(setting);
            n = frames_in_use();
            // Keep most of the working set from the last phase so that pages
            // left in inactive frames come back into play.
            for (k = 0; k < 8; k++) begin
                pool[$urandom_range(2, POOL_SIZE - 1)] = PAGE_W'($urandom_range(0, 16'hFFFF));
            end
            span = $urandom_range(n, 2 * n + 2);
            if (span > POOL_SIZE) span = POOL_SIZE;
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 88;
                default: idle_pct = 15;
            endcase

            for (k = 0; k < PHASE_LEN; k++) begin
                // Mostly a working set a bit larger than the store, so hits,
                // second chances and evictions all happen; some fully random
                // pages mostly fault.
                if ($urandom_range(0, 4) == 0) page = PAGE_W'($urandom_range(0, 16'hFFFF));
                else page = pool[$urandom_range(0, span - 1)];
                send_access(page, idle_pct, 1'b0, no_res);
                // Now and then let the engine drain completely mid-phase.
                if ($urandom_range(0, 59) == 0) wait_idle();
            end
            wait_idle();
        end

        // Allow for a late result word before declaring the run clean.
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
